### sv/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
package hpt_pkg;

  // Item kind carried on the input tuser bit.
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_XFORM = 1'b1
  } kind_t;

  localparam int IDX_W       = 4;
  localparam int COEFF_COUNT = 12;
  localparam int ROWS        = 3;
  localparam int COLS        = 4;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

### sv/hpt_front.sv
// Front end: accepts items, drops out-of-range loads, queues commands for the back end.
module hpt_front #(
  parameter int CW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hpt_pkg::kind_t            in_kind,
  input  logic [hpt_pkg::IDX_W-1:0] in_idx,
  input  logic [CW-1:0]             in_value,
  input  logic [CW-1:0]             in_x,
  input  logic [CW-1:0]             in_y,
  input  logic [CW-1:0]             in_z,
  output logic                      q_valid,
  input  logic                      q_ready,
  output hpt_pkg::kind_t            q_kind,
  output logic [hpt_pkg::IDX_W-1:0] q_idx,
  output logic [CW-1:0]             q_value,
  output logic [CW-1:0]             q_x,
  output logic [CW-1:0]             q_y,
  output logic [CW-1:0]             q_z
);

  hpt_pkg::kind_t            kind_q  [hpt_pkg::QUEUE_DEPTH];
  logic [hpt_pkg::IDX_W-1:0] idx_q   [hpt_pkg::QUEUE_DEPTH];
  logic [CW-1:0]             value_q [hpt_pkg::QUEUE_DEPTH];
  logic [CW-1:0]             x_q     [hpt_pkg::QUEUE_DEPTH];
  logic [CW-1:0]             y_q     [hpt_pkg::QUEUE_DEPTH];
  logic [CW-1:0]             z_q     [hpt_pkg::QUEUE_DEPTH];

  logic [hpt_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hpt_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hpt_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  logic accept, drop, push, pop;

  assign in_ready = (cnt_r != hpt_pkg::QCNT_W'(hpt_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  // loads to a coefficient slot that does not exist are swallowed here
  assign drop     = (in_kind == hpt_pkg::KIND_LOAD) &&
                    (in_idx >= hpt_pkg::IDX_W'(hpt_pkg::COEFF_COUNT));
  assign push     = accept && !drop;
  assign pop      = q_valid && q_ready;

  assign q_valid = (cnt_r != '0);
  assign q_kind  = kind_q[rd_ptr_r];
  assign q_idx   = idx_q[rd_ptr_r];
  assign q_value = value_q[rd_ptr_r];
  assign q_x     = x_q[rd_ptr_r];
  assign q_y     = y_q[rd_ptr_r];
  assign q_z     = z_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr_r]  <= in_kind;
      idx_q[wr_ptr_r]   <= in_idx;
      value_q[wr_ptr_r] <= in_value;
      x_q[wr_ptr_r]     <= in_x;
      y_q[wr_ptr_r]     <= in_y;
      z_q[wr_ptr_r]     <= in_z;
    end
  end

endmodule

### sv/hpt_back.sv
// Back end: coefficient registers and the dot-product / round / saturate pipeline.
module hpt_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  hpt_pkg::kind_t            q_kind,
  input  logic [hpt_pkg::IDX_W-1:0] q_idx,
  input  logic [CW-1:0]             q_value,
  input  logic [CW-1:0]             q_x,
  input  logic [CW-1:0]             q_y,
  input  logic [CW-1:0]             q_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CW-1:0]             out_x,
  output logic [CW-1:0]             out_y,
  output logic [CW-1:0]             out_z,
  output logic                      out_sat
);

  localparam int PW  = 2 * CW;        // one exact product
  localparam int AW  = PW + 1;        // pair sum
  localparam int SW  = PW + 2;        // full dot product
  localparam int RW  = SW + 1;        // magnitude plus rounding half
  localparam int KW  = RW - FB;       // rounded magnitude, widest case
  localparam int NR  = hpt_pkg::ROWS;
  localparam int NC  = hpt_pkg::COLS;

  localparam logic [RW-1:0] HALF_Q   = RW'(1) << (FB - 1);
  localparam logic [RW-1:0] HALF_I   = RW'(1) << (2 * FB - 1);
  localparam logic [CW-1:0] LIM_POS  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] LIM_NEG  = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] ONE_Q    = CW'(1) << FB;

  // ---- configuration and coefficients ----
  logic round_en_r;
  logic [CW-1:0] coeff_r [hpt_pkg::COEFF_COUNT];

  logic load_pop;
  assign load_pop = q_valid && (q_kind == hpt_pkg::KIND_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      round_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hpt_pkg::COEFF_COUNT; i++) begin
        coeff_r[i] <= ((i == 0) || (i == 5) || (i == 10)) ? ONE_Q : '0;
      end
    end else if (load_pop) begin
      coeff_r[q_idx] <= q_value;
    end
  end

  // ---- pipeline control ----
  logic v_p_r, v_a_r, v_t_r, v_m_r, v_r_r, v_o_r;
  logic adv_p, adv_a, adv_t, adv_m, adv_r, adv_o;
  logic xf_pop;

  assign adv_o = !v_o_r || out_ready;
  assign adv_r = !v_r_r || adv_o;
  assign adv_m = !v_m_r || adv_r;
  assign adv_t = !v_t_r || adv_m;
  assign adv_a = !v_a_r || adv_t;
  assign adv_p = !v_p_r || adv_a;

  assign q_ready = (q_kind == hpt_pkg::KIND_LOAD) || adv_p;
  assign xf_pop  = q_valid && (q_kind == hpt_pkg::KIND_XFORM) && adv_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= 1'b0;
      v_a_r <= 1'b0;
      v_t_r <= 1'b0;
      v_m_r <= 1'b0;
      v_r_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      if (adv_p) v_p_r <= xf_pop;
      if (adv_a) v_a_r <= v_p_r;
      if (adv_t) v_t_r <= v_a_r;
      if (adv_m) v_m_r <= v_t_r;
      if (adv_r) v_r_r <= v_m_r;
      if (adv_o) v_o_r <= v_r_r;
    end
  end

  // ---- one lane per output row ----
  logic [CW-1:0] res_w [NR];
  logic          sat_w [NR];

  for (genvar r = 0; r < NR; r++) begin : g_row
    logic signed [CW-1:0] cx, cy, cz, pxs, pys, pzs;
    logic [CW-1:0]        cw;
    logic signed [PW-1:0] prod_r [NC];
    logic signed [AW-1:0] pair0_r, pair1_r;
    logic signed [SW-1:0] tot_r;
    logic [SW-1:0]        mag_r;
    logic                 neg_m_r, neg_r_r;
    logic [RW-1:0]        rsum;
    logic [KW-1:0]        k_r;
    logic [CW-1:0]        limit, lim_k, val;
    logic                 sat;

    assign cx  = coeff_r[r * NC + 0];
    assign cy  = coeff_r[r * NC + 1];
    assign cz  = coeff_r[r * NC + 2];
    assign cw  = coeff_r[r * NC + 3];
    assign pxs = q_x;
    assign pys = q_y;
    assign pzs = q_z;

    // products; the w term is the translation scaled by 1.0
    always_ff @(posedge clk) begin
      if (adv_p) begin
        prod_r[0] <= cx * pxs;
        prod_r[1] <= cy * pys;
        prod_r[2] <= cz * pzs;
        prod_r[3] <= {{(CW - FB){cw[CW-1]}}, cw, {FB{1'b0}}};
      end
    end

    always_ff @(posedge clk) begin
      if (adv_a) begin
        pair0_r <= AW'(prod_r[0]) + AW'(prod_r[1]);
        pair1_r <= AW'(prod_r[2]) + AW'(prod_r[3]);
      end
    end

    always_ff @(posedge clk) begin
      if (adv_t) begin
        tot_r <= SW'(pair0_r) + SW'(pair1_r);
      end
    end

    always_ff @(posedge clk) begin
      if (adv_m) begin
        neg_m_r <= tot_r[SW-1];
        mag_r   <= tot_r[SW-1] ? SW'(-tot_r) : SW'(tot_r);
      end
    end

    // round half away from zero on the magnitude
    assign rsum = {1'b0, mag_r} + (round_en_r ? HALF_I : HALF_Q);

    always_ff @(posedge clk) begin
      if (adv_r) begin
        neg_r_r <= neg_m_r;
        k_r     <= round_en_r ? KW'(rsum >> (2 * FB)) : KW'(rsum >> FB);
      end
    end

    assign limit = neg_r_r ? LIM_NEG : LIM_POS;
    assign lim_k = round_en_r ? (limit >> FB) : limit;
    assign sat   = (k_r > KW'(lim_k));
    assign val   = sat ? limit : (round_en_r ? (CW'(k_r) << FB) : CW'(k_r));

    assign res_w[r] = neg_r_r ? (~val + 1'b1) : val;
    assign sat_w[r] = sat;
  end

  // ---- output register ----
  logic [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic          out_sat_r;

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_x_r   <= res_w[0];
      out_y_r   <= res_w[1];
      out_z_r   <= res_w[2];
      out_sat_r <= sat_w[0] | sat_w[1] | sat_w[2];
    end
  end

  assign out_valid = v_o_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_sat   = out_sat_r;

endmodule

### sv/homogeneous_point_transform_top.sv
// Top level of the homogeneous point transform: stream ports, front end and back end.
// Points pass the queue, then the product, pair, total, magnitude, round and output registers.
// Throughput: one item per cycle unless out_tready stalls; the six-stage back pipeline (three
// multipliers per row) takes one point per cycle while not stalled; in-range loads take one
// queue slot, no pipeline stage and give no result. Reset (rst_n low at a clock edge): queue
// emptied, pipeline drained, coefficients set to identity rows 0 to 2, rounding enabled.
module homogeneous_point_transform_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,

  // configuration: round_enable
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,

  // input stream
  input  logic in_tvalid,
  output logic in_tready,
  // tdata from bit 0: coeff_index, coeff_value, point_x, point_y, point_z, zero pad
  input  logic [((hpt_pkg::IDX_W + 4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // tuser: opcode (0 load coefficient, 1 transform point)
  input  logic in_tuser,

  // result stream
  output logic out_tvalid,
  input  logic out_tready,
  // tdata from bit 0: out_x, out_y, out_z, zero pad
  output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // tuser: saturated
  output logic out_tuser
);

  localparam int CW     = COORD_WIDTH;
  localparam int IW     = hpt_pkg::IDX_W;
  localparam int OUT_DW = ((3 * CW + 7) / 8) * 8;

  // unpacked input fields
  hpt_pkg::kind_t in_kind;
  logic [IW-1:0]  in_idx;
  logic [CW-1:0]  in_value, in_x, in_y, in_z;

  assign in_kind  = hpt_pkg::kind_t'(in_tuser);
  assign in_idx   = in_tdata[IW-1:0];
  assign in_value = in_tdata[IW +: CW];
  assign in_x     = in_tdata[IW + CW +: CW];
  assign in_y     = in_tdata[IW + 2 * CW +: CW];
  assign in_z     = in_tdata[IW + 3 * CW +: CW];

  // command queue front -> back
  logic           q_valid, q_ready;
  hpt_pkg::kind_t q_kind;
  logic [IW-1:0]  q_idx;
  logic [CW-1:0]  q_value, q_x, q_y, q_z;

  hpt_front #(
    .CW (CW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_kind),
    .in_idx   (in_idx),
    .in_value (in_value),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_kind   (q_kind),
    .q_idx    (q_idx),
    .q_value  (q_value),
    .q_x      (q_x),
    .q_y      (q_y),
    .q_z      (q_z)
  );

  // back end outputs
  logic [CW-1:0] res_x, res_y, res_z;

  hpt_back #(
    .CW (CW),
    .FB (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_kind      (q_kind),
    .q_idx       (q_idx),
    .q_value     (q_value),
    .q_x         (q_x),
    .q_y         (q_y),
    .q_z         (q_z),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_x       (res_x),
    .out_y       (res_y),
    .out_z       (res_z),
    .out_sat     (out_tuser)
  );

  // pack result transfer; pad bits are zero
  assign out_tdata = OUT_DW'({res_z, res_y, res_x});

endmodule

### bench/tb_homogeneous_point_transform_top.sv
// Self-checking testbench for homogeneous_point_transform_top.
module tb_homogeneous_point_transform_top;

  localparam int QW      = 32;               // coordinate width
  localparam int FRAC    = 16;               // fraction bits
  localparam int IN_W    = ((hpt_pkg::IDX_W + 4 * QW + 7) / 8) * 8;
  localparam int OUT_W   = ((3 * QW + 7) / 8) * 8;
  localparam int SETTLE  = 16;               // cycles for queued loads to retire
  localparam int LIMIT   = 400000;           // cycle budget for the whole run
  localparam int RAND_N  = 150;              // random items per rounding phase

  // One input transfer as the bench sees it.
  typedef struct {
    hpt_pkg::kind_t     kind;
    logic [3:0]         idx;
    logic signed [31:0] coeff;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } xform_item_t;

  // One expected output transfer.
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clipped;
  } point_result_t;

  // Tracks the matrix and rounding mode, predicts each transform and checks
  // output transfers in order.
  class xform_scoreboard;
    logic signed [31:0] coeffs[hpt_pkg::COEFF_COUNT];
    bit                 round_on;
    point_result_t      expected_points[$];
    int                 mismatch_count;

    function new();
      foreach (coeffs[i]) coeffs[i] = '0;
      coeffs[0]  = 32'h0001_0000;
      coeffs[5]  = 32'h0001_0000;
      coeffs[10] = 32'h0001_0000;
      round_on = 1'b1;
      mismatch_count = 0;
    endfunction

    // Round half away from zero, then clip to the signed coordinate range.
    function logic [31:0] round_and_clip(logic signed [79:0] sum, inout bit clipped);
      logic [79:0] mag;
      logic [79:0] lim;
      int          sh;
      bit          neg;
      neg = sum[79];
      mag = neg ? -sum : sum;
      sh  = round_on ? 2 * FRAC : FRAC;
      mag = (mag + (80'd1 << (sh - 1))) >> sh;
      lim = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
      if (mag > (round_on ? (lim >> FRAC) : lim)) begin
        clipped = 1'b1;
        mag = lim;
      end else if (round_on) begin
        mag = mag << FRAC;
      end
      if (neg) mag = -mag;
      return mag[31:0];
    endfunction

    function point_result_t transform_point(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] pz);
      point_result_t      res;
      logic signed [31:0] pt[3];
      logic signed [79:0] sum;
      logic [31:0]        comp[3];
      bit                 clipped;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      clipped = 1'b0;
      for (int r = 0; r < hpt_pkg::ROWS; r++) begin
        sum = '0;
        for (int c = 0; c < 3; c++)
          sum = sum + longint'(coeffs[r * hpt_pkg::COLS + c]) * longint'(pt[c]);
        // w = 1.0 picks up the translation column
        sum = sum + longint'(coeffs[r * hpt_pkg::COLS + 3]) * 64'sd65536;
        comp[r] = round_and_clip(sum, clipped);
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      res.clipped = clipped;
      return res;
    endfunction

    function void note_transfer(xform_item_t it);
      if (it.kind == hpt_pkg::KIND_LOAD) begin
        if (it.idx < hpt_pkg::COEFF_COUNT) coeffs[it.idx] = it.coeff;
      end else begin
        expected_points.push_back(transform_point(it.px, it.py, it.pz));
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic clipped);
      point_result_t want;
      if (expected_points.size() == 0) begin
        $error("result transfer with nothing expected: %h", data);
        mismatch_count++;
        return;
      end
      want = expected_points.pop_front();
      compare_field("out_x", want.x, data[31:0]);
      compare_field("out_y", want.y, data[63:32]);
      compare_field("out_z", want.z, data[95:64]);
      compare_field("saturated", {31'b0, want.clipped}, {31'b0, clipped});
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic             cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // coeff_index, coeff_value, point_x, point_y, point_z, pad
  logic             in_tuser;   // opcode
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // out_x, out_y, out_z
  logic             out_tuser;  // saturated

  xform_scoreboard sb;
  int              cycle_count;
  int              src_calm;    // sender: cycles left in a gap-free stretch
  int              sink_calm;   // receiver: cycles left with ready held high
  int              sink_wait;   // receiver: cycles left in the current stall

  homogeneous_point_transform_top #(
    .COORD_WIDTH(QW),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: random stalls with occasional stretches of steady ready.
  initial begin
    out_tready = 1'b1;
    sink_calm  = 0;
    sink_wait  = 0;
    forever begin
      @(posedge clk);
      if (sink_wait > 0) begin
        sink_wait--;
        if (sink_wait == 0) out_tready <= 1'b1;
      end else if (sink_calm > 0) begin
        sink_calm--;
      end else if ($urandom_range(0, 99) < 3) begin
        sink_calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 99) < 30) begin
        sink_wait = pick_gap();
        if (sink_wait > 0) out_tready <= 1'b0;
      end
    end
  end

  // Output monitor: every accepted result transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Drive one item; returns at the edge where the transfer happens, valid still high.
  task automatic send_item(xform_item_t it);
    int gap;
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 2) src_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {4'b0, it.pz, it.py, it.px, it.coeff, it.idx};
    do @(posedge clk); while (!in_tready);
    sb.note_transfer(it);
  endtask

  // Sender holds off until every result is back and queued loads have retired.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_points.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rounding(bit on);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.round_on = on;
  endtask

  function automatic xform_item_t make_load(logic [3:0] idx, logic [31:0] value);
    xform_item_t it;
    it.kind  = hpt_pkg::KIND_LOAD;
    it.idx   = idx;
    it.coeff = value;
    it.px    = $urandom;   // ignored by a load
    it.py    = $urandom;
    it.pz    = $urandom;
    return it;
  endfunction

  function automatic xform_item_t make_xform(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    xform_item_t it;
    it.kind  = hpt_pkg::KIND_XFORM;
    it.idx   = 4'($urandom);   // ignored by a transform
    it.coeff = $urandom;
    it.px    = x;
    it.py    = y;
    it.pz    = z;
    return it;
  endfunction

  // Q16.16 value: mostly modest magnitudes, some exact halves, extremes and raw bits.
  function automatic logic [31:0] rand_q(bit is_coeff);
    case ($urandom_range(0, 19))
      0, 1: begin
        case ($urandom_range(0, 6))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          4: return 32'hFFFF_0000;
          5: return 32'h0000_8000;
          default: return 32'hFFFF_8000;
        endcase
      end
      2, 3: return $urandom;
      4, 5: return ((int'($urandom_range(0, 4095)) - 2048) <<< FRAC) | 32'h0000_8000;
      default: begin
        if (is_coeff) return int'($urandom_range(0, 1 << 18)) - (1 << 17);
        return int'($urandom_range(0, 1 << 27)) - (1 << 26);
      end
    endcase
  endfunction

  // Random item: about a quarter loads (some to the unused indexes), rest transforms.
  function automatic xform_item_t random_item();
    logic [3:0] idx;
    if ($urandom_range(0, 3) == 0) begin
      idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      return make_load(idx, rand_q(1'b1));
    end
    return make_xform(rand_q(1'b0), rand_q(1'b0), rand_q(1'b0));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      // Mid-phase drain: sender pauses until the pipeline is empty.
      if (i == count / 2) wait_idle();
      send_item(random_item());
    end
  endtask

  initial begin
    sb          = new();
    src_calm    = 0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = hpt_pkg::KIND_LOAD;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: identity after reset, rounding on ---
    send_item(make_xform(32'h0001_8000, 32'hFFFD_8000, 32'h0000_8000)); // halves round out
    send_item(make_xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000)); // max clips, min exact
    send_item(make_xform(32'h0000_7FFF, 32'hFFFF_8000, 32'hFFFF_7FFF)); // just below/at half
    send_item(make_load(4'd12, 32'h7FFF_FFFF));                         // unused index
    send_item(make_load(4'd15, 32'h8000_0000));                         // unused index
    send_item(make_xform(32'h0001_0000, 32'h0001_0000, 32'h0001_0000)); // matrix untouched
    send_item(make_load(4'd3, 32'h7FFF_FFFF));                          // max x translation
    send_item(make_load(4'd0, 32'h8000_0000));                          // most negative scale
    send_item(make_xform(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000)); // huge negative
    send_item(make_xform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000)); // huge positive
    send_item(make_load(4'd7, 32'h8000_0000));
    send_item(make_load(4'd11, 32'h0001_8000));
    send_item(make_load(4'd5, 32'h7FFF_FFFF));
    send_item(make_load(4'd10, 32'hFFFF_0000));
    send_item(make_xform(32'h0000_0000, 32'h0001_0000, 32'h0000_8000));
    send_item(make_xform(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF));
    send_item(make_load(4'd8, 32'h0000_0001));                          // smallest step
    send_item(make_xform(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
    random_phase(RAND_N);

    // --- full-fraction mode ---
    write_rounding(1'b0);
    send_item(make_xform(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
    random_phase(RAND_N);

    write_rounding(1'b1);
    random_phase(RAND_N);

    write_rounding(1'b0);
    random_phase(RAND_N);

    // Let the last results come back, then watch for strays.
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
sv/hpt_pkg.sv
sv/hpt_front.sv
sv/hpt_back.sv
sv/homogeneous_point_transform_top.sv
bench/tb_homogeneous_point_transform_top.sv
